### rtl/core/ir_pulse_distance_receiver_defines.svh
`ifndef IR_PULSE_DISTANCE_RECEIVER_DEFINES_SVH
`define IR_PULSE_DISTANCE_RECEIVER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define IPDR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ipdr same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define IPDR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ipdr next-cycle check failed");

`endif

### rtl/core/ipdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipdr_pkg;

  localparam int DUR_W       = 16;
  localparam int REG_W       = 16;
  localparam int REG_IDX_W   = 3;
  localparam int CNT_W       = 3;
  localparam int DATA_W      = 32;
  localparam int RECIP_SHIFT = 24;
  localparam int STOP_DIVISOR = 10;

  typedef enum logic [1:0] {
    OP_FALL    = 2'd0,
    OP_RISE    = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_READY       = 2'd0,
    MODE_RECEIVING   = 2'd1,
    MODE_FRAME_READY = 2'd2,
    MODE_OVERRUN     = 2'd3
  } mode_t;

  localparam logic [REG_IDX_W-1:0] REG_PREAMBLE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ZERO     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ONE      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STOP     = 3'd3;

  localparam logic [REG_W-1:0] PREAMBLE_RESET = 16'd13500;
  localparam logic [REG_W-1:0] ZERO_RESET     = 16'd1125;
  localparam logic [REG_W-1:0] ONE_RESET      = 16'd2250;
  localparam logic [REG_W-1:0] STOP_RESET     = 16'd560;

  typedef struct packed {
    logic [REG_W-1:0] pre_nom;
    logic [REG_W-1:0] pre_slack;
    logic [REG_W-1:0] zero_nom;
    logic [REG_W-1:0] zero_slack;
    logic [REG_W-1:0] one_nom;
    logic [REG_W-1:0] one_slack;
    logic [REG_W-1:0] stop_nom;
    logic [REG_W-1:0] stop_slack;
  } timing_cfg_t;

  typedef struct packed {
    logic pre;
    logic zero;
    logic one;
    logic stop;
  } hit_t;

endpackage

`default_nettype wire

### rtl/core/ipdr_channels.sv
`timescale 1ns / 1ps
`default_nettype none

interface ipdr_item_if;
  import ipdr_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic [DUR_W-1:0] duration_us;

  modport source(output valid, output opcode, output duration_us, input ready);
  modport sink(input valid, input opcode, input duration_us, output ready);
endinterface

interface ipdr_result_if;
  import ipdr_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        receiver_state;
  logic [CNT_W-1:0]  bytes_received;
  logic [CNT_W-1:0]  bit_position;
  logic [DATA_W-1:0] frame_data;
  logic              frame_valid;

  modport source(output valid, output receiver_state, output bytes_received,
                 output bit_position, output frame_data, output frame_valid,
                 input ready);
  modport sink(input valid, input receiver_state, input bytes_received,
               input bit_position, input frame_data, input frame_valid,
               output ready);
endinterface

`default_nettype wire

### rtl/core/ipdr_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module ipdr_cfg #(
  parameter int TOLERANCE_DIVISOR = 5
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            write_en,
  input  wire logic [ipdr_pkg::REG_IDX_W-1:0]  index,
  input  wire logic [ipdr_pkg::REG_W-1:0]      data,
  output ipdr_pkg::timing_cfg_t                cfg
);
  import ipdr_pkg::*;

  localparam int PROD_W = REG_W + RECIP_SHIFT;
  localparam logic [RECIP_SHIFT-1:0] TOL_RECIP =
    RECIP_SHIFT'((2 ** RECIP_SHIFT + TOLERANCE_DIVISOR - 1) / TOLERANCE_DIVISOR);
  localparam logic [RECIP_SHIFT-1:0] STOP_RECIP =
    RECIP_SHIFT'((2 ** RECIP_SHIFT + STOP_DIVISOR - 1) / STOP_DIVISOR);
  localparam logic [REG_W-1:0] PRE_SLACK_RESET  = REG_W'(PREAMBLE_RESET / TOLERANCE_DIVISOR);
  localparam logic [REG_W-1:0] ZERO_SLACK_RESET = REG_W'(ZERO_RESET / TOLERANCE_DIVISOR);
  localparam logic [REG_W-1:0] ONE_SLACK_RESET  = REG_W'(ONE_RESET / TOLERANCE_DIVISOR);
  localparam logic [REG_W-1:0] STOP_SLACK_RESET = REG_W'(STOP_RESET / STOP_DIVISOR);

  logic [PROD_W-1:0] tol_prod;
  logic [PROD_W-1:0] stop_prod;
  logic [REG_W-1:0]  tol_slack;
  logic [REG_W-1:0]  stop_slack;

  // exact quotient by reciprocal: the error term stays below one unit for 16-bit data
  assign tol_prod   = {{RECIP_SHIFT{1'b0}}, data} * {{REG_W{1'b0}}, TOL_RECIP};
  assign stop_prod  = {{RECIP_SHIFT{1'b0}}, data} * {{REG_W{1'b0}}, STOP_RECIP};
  assign tol_slack  = tol_prod[RECIP_SHIFT +: REG_W];
  assign stop_slack = stop_prod[RECIP_SHIFT +: REG_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pre_nom    <= PREAMBLE_RESET;
      cfg.pre_slack  <= PRE_SLACK_RESET;
      cfg.zero_nom   <= ZERO_RESET;
      cfg.zero_slack <= ZERO_SLACK_RESET;
      cfg.one_nom    <= ONE_RESET;
      cfg.one_slack  <= ONE_SLACK_RESET;
      cfg.stop_nom   <= STOP_RESET;
      cfg.stop_slack <= STOP_SLACK_RESET;
    end else if (write_en) begin
      unique case (index)
        REG_PREAMBLE: begin
          cfg.pre_nom   <= data;
          cfg.pre_slack <= tol_slack;
        end
        REG_ZERO: begin
          cfg.zero_nom   <= data;
          cfg.zero_slack <= tol_slack;
        end
        REG_ONE: begin
          cfg.one_nom   <= data;
          cfg.one_slack <= tol_slack;
        end
        REG_STOP: begin
          cfg.stop_nom   <= data;
          cfg.stop_slack <= stop_slack;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/ipdr_classify.sv
`timescale 1ns / 1ps
`default_nettype none

module ipdr_classify (
  input  wire logic [ipdr_pkg::DUR_W-1:0] duration_us,
  input  wire ipdr_pkg::timing_cfg_t      cfg,
  output ipdr_pkg::hit_t                  hits
);
  import ipdr_pkg::*;

  function automatic logic in_window(input logic [DUR_W-1:0] t,
                                     input logic [REG_W-1:0] nom,
                                     input logic [REG_W-1:0] slack);
    logic [REG_W:0]   hi;
    logic [REG_W-1:0] lo;
    hi = {1'b0, nom} + {1'b0, slack};
    lo = nom - slack;
    return ({1'b0, t} <= hi) && (t >= lo);
  endfunction

  assign hits.pre  = in_window(duration_us, cfg.pre_nom, cfg.pre_slack);
  assign hits.zero = in_window(duration_us, cfg.zero_nom, cfg.zero_slack);
  assign hits.one  = in_window(duration_us, cfg.one_nom, cfg.one_slack);
  assign hits.stop = in_window(duration_us, cfg.stop_nom, cfg.stop_slack);

endmodule

`default_nettype wire

### rtl/core/ipdr_engine.sv
`timescale 1ns / 1ps
`default_nettype none

`include "ir_pulse_distance_receiver_defines.svh"

module ipdr_engine #(
  parameter int FRAME_BYTES = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         fire,
  input  wire ipdr_pkg::op_t                op,
  input  wire ipdr_pkg::hit_t               hits,
  output ipdr_pkg::mode_t                   mode,
  output logic [ipdr_pkg::CNT_W-1:0]        byte_counter,
  output logic [ipdr_pkg::CNT_W-1:0]        bit_counter,
  output logic [ipdr_pkg::DATA_W-1:0]       frame_data
);
  import ipdr_pkg::*;

  localparam int STORE_BYTES = (FRAME_BYTES < 4) ? FRAME_BYTES : 4;
  localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_BYTES);

  logic                        timing_active;
  logic [STORE_BYTES-1:0][7:0] store;

  mode_t                       mode_next;
  logic                        timing_next;
  logic [CNT_W-1:0]            byte_next;
  logic [CNT_W-1:0]            bit_next;
  logic [STORE_BYTES-1:0][7:0] store_next;
  logic                        take;
  logic                        bit_val;
  logic [CNT_W:0]              byte_inc;

  assign byte_inc = {1'b0, byte_counter} + (CNT_W + 1)'(1);

  always_comb begin
    mode_next   = mode;
    timing_next = timing_active;
    byte_next   = byte_counter;
    bit_next    = bit_counter;
    store_next  = store;
    take        = 1'b0;
    bit_val     = 1'b0;
    if (fire) begin
      unique case (op)
        OP_RELEASE: begin
          if (mode == MODE_FRAME_READY) begin
            mode_next   = MODE_READY;
            byte_next   = '0;
            bit_next    = '0;
            timing_next = 1'b0;
          end
        end
        OP_TIMEOUT: begin
          timing_next = 1'b0;
          if (mode != MODE_FRAME_READY) begin
            mode_next = MODE_READY;
            byte_next = '0;
            bit_next  = '0;
          end
        end
        OP_RISE: begin
          if (mode == MODE_FRAME_READY) begin
            timing_next = 1'b0;
          end else if (hits.stop) begin
            timing_next = 1'b0;
            bit_next    = '0;
            if (byte_counter == FRAME_CNT && mode != MODE_OVERRUN) begin
              mode_next = MODE_FRAME_READY;
            end else begin
              mode_next = MODE_READY;
              byte_next = '0;
            end
          end
        end
        OP_FALL: begin
          if (mode == MODE_FRAME_READY) begin
            timing_next = 1'b0;
          end else if (!timing_active) begin
            timing_next = 1'b1;
          end else if (mode == MODE_READY && hits.pre) begin
            mode_next   = MODE_RECEIVING;
            byte_next   = '0;
            bit_next    = '0;
            timing_next = 1'b1;
          end else if (mode == MODE_RECEIVING && (hits.zero || hits.one)) begin
            take        = 1'b1;
            bit_val     = !hits.zero;
            timing_next = 1'b1;
          end else begin
            mode_next   = MODE_READY;
            byte_next   = '0;
            bit_next    = '0;
            timing_next = 1'b0;
          end
        end
      endcase
    end
    if (take) begin
      for (int i = 0; i < STORE_BYTES; i++) begin
        if (byte_counter == CNT_W'(i)) begin
          store_next[i][bit_counter] = bit_val;
        end
      end
      bit_next = bit_counter + CNT_W'(1);
      if (&bit_counter) begin
        if (byte_inc > {1'b0, FRAME_CNT}) begin
          mode_next = MODE_OVERRUN;
          byte_next = '0;
        end else begin
          byte_next = byte_inc[CNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_READY;
      timing_active <= 1'b0;
      byte_counter  <= '0;
      bit_counter   <= '0;
      store         <= '0;
    end else begin
      mode          <= mode_next;
      timing_active <= timing_next;
      byte_counter  <= byte_next;
      bit_counter   <= bit_next;
      store         <= store_next;
    end
  end

  always_comb begin
    frame_data = '0;
    for (int i = 0; i < STORE_BYTES; i++) begin
      frame_data[8*i +: 8] = store[i];
    end
  end

  `IPDR_ASSERT_IMP(a_held_frame_full, clk, rst, mode == MODE_FRAME_READY, byte_counter == FRAME_CNT)
  `IPDR_ASSERT_IMP(a_overrun_clear, clk, rst, mode == MODE_OVERRUN, byte_counter == '0 && bit_counter == '0)
  `IPDR_ASSERT_NEXT(a_hold_when_idle, clk, rst, !fire, $stable(mode) && $stable(byte_counter) && $stable(store))

endmodule

`default_nettype wire

### rtl/core/ir_pulse_distance_receiver.sv
// Pulse-distance IR frame receiver.
// item channel: one request per line event; opcode 0 falling edge, 1 rising edge,
//   2 timeout or capture overflow, 3 release of a held frame; duration_us is the
//   captured time since the last falling edge, masked to TIMER_WIDTH bits.
// result channel: exactly one result per request, showing receiver state,
//   byte and bit counters, the stored frame bytes and a frame-ready flag.
// cfg port: write cfg_data into register cfg_index (0 preamble, 1 zero, 2 one,
//   3 stop mark) on any cycle with cfg_write_en; write only while idle.
// Path: an accepted request waits in the input register; then window compare
//   and state update write the state registers, which double as the result
//   register. Throughput: one request per cycle while results are taken;
//   the single-pass update sets that figure.
// When the result side stalls, the held result and state stay put, one more
//   request waits in the input register, and then item.ready drops.
// Reset: configuration returns to its defaults, the receiver goes to ready with
//   counters and frame bytes cleared, and both channels are emptied.
`timescale 1ns / 1ps
`default_nettype none

module ir_pulse_distance_receiver #(
  parameter int FRAME_BYTES       = 4,
  parameter int TOLERANCE_DIVISOR = 5,
  parameter int TIMER_WIDTH       = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  ipdr_item_if.sink                            item,
  ipdr_result_if.source                        result,
  input  wire logic                            cfg_write_en,
  input  wire logic [ipdr_pkg::REG_IDX_W-1:0]  cfg_index,
  input  wire logic [ipdr_pkg::REG_W-1:0]      cfg_data
);
  import ipdr_pkg::*;

  localparam logic [DUR_W-1:0] DUR_MASK =
    (TIMER_WIDTH >= DUR_W) ? '1 : DUR_W'((64'd1 << TIMER_WIDTH) - 64'd1);

  logic             in_q_valid;
  op_t              in_q_op;
  logic [DUR_W-1:0] in_q_dur;
  logic             out_valid;
  logic             fire;
  logic             accept;

  timing_cfg_t      cfg;
  hit_t             hits;
  mode_t            mode;
  logic [CNT_W-1:0] byte_counter;
  logic [CNT_W-1:0] bit_counter;
  logic [DATA_W-1:0] frame_data;

  assign fire       = in_q_valid && (!out_valid || result.ready);
  assign item.ready = !in_q_valid || fire;
  assign accept     = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        in_q_valid <= 1'b1;
      end else if (fire) begin
        in_q_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q_op  <= op_t'(item.opcode);
      in_q_dur <= item.duration_us & DUR_MASK;
    end
  end

  ipdr_cfg #(
    .TOLERANCE_DIVISOR(TOLERANCE_DIVISOR)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .write_en (cfg_write_en),
    .index    (cfg_index),
    .data     (cfg_data),
    .cfg      (cfg)
  );

  ipdr_classify u_classify (
    .duration_us (in_q_dur),
    .cfg         (cfg),
    .hits        (hits)
  );

  ipdr_engine #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .op           (in_q_op),
    .hits         (hits),
    .mode         (mode),
    .byte_counter (byte_counter),
    .bit_counter  (bit_counter),
    .frame_data   (frame_data)
  );

  assign result.valid          = out_valid;
  assign result.receiver_state = mode;
  assign result.bytes_received = byte_counter;
  assign result.bit_position   = bit_counter;
  assign result.frame_data     = frame_data;
  assign result.frame_valid    = (mode == MODE_FRAME_READY);

endmodule

`default_nettype wire

### bench/tb_ir_pulse_distance_receiver.sv
`timescale 1ns / 1ps

module tb_ir_pulse_distance_receiver;
  import ipdr_pkg::*;

  localparam int FRAME_BYTES = 4;
  localparam int TOL_DIV     = 5;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]  state;
    logic [2:0]  nbytes;
    logic [2:0]  nbits;
    logic [31:0] data;
    logic        fvalid;
  } rx_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  ipdr_item_if   item_ch ();
  ipdr_result_if result_ch ();

  ir_pulse_distance_receiver #(
    .FRAME_BYTES(FRAME_BYTES),
    .TOLERANCE_DIVISOR(TOL_DIV),
    .TIMER_WIDTH(16)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // decoder model state and timing windows
  mode_t       rx_mode = MODE_READY;
  bit          timing_on = 1'b0;
  logic [2:0]  bit_cnt = '0;
  logic [2:0]  byte_cnt = '0;
  logic [7:0]  frame_mem [FRAME_BYTES] = '{default: 8'h00};
  logic [15:0] pre_nom = PREAMBLE_RESET;
  logic [15:0] zero_nom = ZERO_RESET;
  logic [15:0] one_nom = ONE_RESET;
  logic [15:0] stop_nom = STOP_RESET;

  rx_status_t expected_status [$];
  rx_status_t head;
  int send_idle_pct = 11;
  int recv_stall_pct = 11;
  int hold_cnt = 0;
  int errors = 0;
  int cycles = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_held = 0;
  int n_frames = 0;
  int n_writes = 0;

  function automatic bit in_window(int unsigned t, int unsigned nom, int unsigned div);
    int unsigned slack;
    slack = nom / div;
    return (t <= nom + slack) && (t >= nom - slack);
  endfunction

  function automatic void return_to_ready();
    bit_cnt = '0;
    byte_cnt = '0;
    rx_mode = MODE_READY;
  endfunction

  function automatic void store_bit(bit v);
    if (byte_cnt < FRAME_BYTES) frame_mem[byte_cnt][bit_cnt] = v;
    bit_cnt = bit_cnt + 3'd1;
    if (bit_cnt == 3'd0) begin
      byte_cnt = byte_cnt + 3'd1;
      if (byte_cnt > FRAME_BYTES) begin
        rx_mode = MODE_OVERRUN;
        byte_cnt = '0;
      end
    end
  endfunction

  function automatic rx_status_t decode_event(op_t op, logic [15:0] dur);
    rx_status_t st;
    int unsigned t;
    t = dur;
    case (op)
      OP_RELEASE: begin
        if (rx_mode == MODE_FRAME_READY) begin
          return_to_ready();
          timing_on = 1'b0;
        end
      end
      OP_TIMEOUT: begin
        timing_on = 1'b0;
        if (rx_mode != MODE_FRAME_READY) return_to_ready();
      end
      default: begin
        if (rx_mode == MODE_FRAME_READY) begin
          timing_on = 1'b0;
        end else if (op == OP_RISE) begin
          if (in_window(t, stop_nom, STOP_DIVISOR)) begin
            timing_on = 1'b0;
            bit_cnt = '0;
            if (byte_cnt == FRAME_BYTES && rx_mode != MODE_OVERRUN) begin
              rx_mode = MODE_FRAME_READY;
              n_held++;
            end else begin
              byte_cnt = '0;
              rx_mode = MODE_READY;
            end
          end
        end else if (!timing_on) begin
          timing_on = 1'b1;
        end else if (rx_mode == MODE_READY && in_window(t, pre_nom, TOL_DIV)) begin
          bit_cnt = '0;
          byte_cnt = '0;
          rx_mode = MODE_RECEIVING;
        end else if (rx_mode == MODE_RECEIVING && in_window(t, zero_nom, TOL_DIV)) begin
          store_bit(1'b0);
        end else if (rx_mode == MODE_RECEIVING && in_window(t, one_nom, TOL_DIV)) begin
          store_bit(1'b1);
        end else begin
          return_to_ready();
          timing_on = 1'b0;
        end
      end
    endcase
    st.state = rx_mode;
    st.nbytes = byte_cnt;
    st.nbits = bit_cnt;
    st.data = {frame_mem[3], frame_mem[2], frame_mem[1], frame_mem[0]};
    st.fvalid = (rx_mode == MODE_FRAME_READY);
    return st;
  endfunction

  // pick a duration inside a window, often right on its bounds
  function automatic logic [15:0] near_nominal(logic [15:0] nom, int unsigned div);
    int unsigned slack;
    int unsigned lo;
    int unsigned hi;
    int unsigned r;
    slack = nom / div;
    lo = nom - slack;
    hi = nom + slack;
    if (hi > 32'hFFFF) hi = 32'hFFFF;
    case ($urandom_range(3))
      0: r = lo;
      1: r = hi;
      default: r = $urandom_range(hi, lo);
    endcase
    return r[15:0];
  endfunction

  task automatic send_event(op_t op, logic [15:0] dur);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.opcode <= op;
    item_ch.duration_us <= dur;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    expected_status.push_back(decode_event(op, dur));
    n_sent++;
  endtask

  // drop the request and wait for all results to come back
  task automatic settle();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      REG_PREAMBLE: pre_nom = val;
      REG_ZERO:     zero_nom = val;
      REG_ONE:      one_nom = val;
      REG_STOP:     stop_nom = val;
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic set_timing(logic [15:0] pre, logic [15:0] zero, logic [15:0] one,
                            logic [15:0] stop);
    settle();
    write_reg(REG_PREAMBLE, pre);
    write_reg(REG_ZERO, zero);
    write_reg(REG_ONE, one);
    write_reg(REG_STOP, stop);
  endtask

  task automatic send_frame(int nbits);
    bit b;
    send_event(OP_FALL, 16'($urandom));
    send_event(OP_FALL, near_nominal(pre_nom, TOL_DIV));
    for (int i = 0; i < nbits; i++) begin
      if ($urandom_range(99) < 2) send_event(OP_FALL, 16'($urandom));
      b = $urandom_range(1);
      send_event(OP_FALL, b ? near_nominal(one_nom, TOL_DIV) : near_nominal(zero_nom, TOL_DIV));
    end
    if ($urandom_range(9) == 0) send_event(OP_RISE, 16'($urandom));
    send_event(OP_RISE, near_nominal(stop_nom, STOP_DIVISOR));
    n_frames++;
  endtask

  task automatic random_traffic(int count);
    int start;
    int r;
    int nbits;
    start = n_sent;
    while (n_sent - start < count) begin
      r = $urandom_range(99);
      if (r < 70) begin
        r = $urandom_range(99);
        if (r < 70) nbits = 32;
        else if (r < 80) nbits = $urandom_range(39, 33);
        else if (r < 88) nbits = $urandom_range(48, 40);
        else nbits = $urandom_range(31, 0);
        send_frame(nbits);
        if ($urandom_range(3) != 0) send_event(OP_RELEASE, 16'($urandom));
      end else begin
        repeat ($urandom_range(8, 1)) begin
          case ($urandom_range(3))
            0: send_event(OP_FALL, near_nominal(pre_nom, TOL_DIV));
            1: send_event(OP_RISE, near_nominal(stop_nom, STOP_DIVISOR));
            default: send_event(op_t'($urandom_range(3)), 16'($urandom));
          endcase
        end
      end
    end
  endtask

  task automatic test_line_events();
    send_event(OP_RELEASE, 16'd0);
    send_event(OP_TIMEOUT, 16'hFFFF);
    send_event(OP_RISE, 16'd0);
    send_event(OP_RISE, 16'hFFFF);
    send_event(OP_RISE, 16'd560);
    send_event(OP_FALL, 16'hFFFF);
    send_event(OP_FALL, 16'd5000);
    send_event(OP_FALL, 16'd0);
    send_event(OP_FALL, 16'd13500);
    send_event(OP_FALL, 16'd2250);
    send_event(OP_FALL, 16'd1125);
    send_event(OP_FALL, 16'd13500);
    send_event(OP_FALL, 16'd0);
    send_event(OP_FALL, 16'd10800);
    send_event(OP_FALL, 16'd2700);
    send_event(OP_FALL, 16'd900);
    send_event(OP_TIMEOUT, 16'd0);
    send_event(OP_FALL, 16'd1);
    send_event(OP_FALL, 16'd16200);
    send_event(OP_FALL, 16'd1800);
    send_event(OP_RISE, 16'd504);
    send_event(OP_RISE, 16'd616);
    send_event(OP_FALL, 16'd3);
    send_event(OP_FALL, 16'd16201);
    send_event(OP_RELEASE, 16'hFFFF);
  endtask

  task automatic test_held_frame();
    send_frame(32);
    send_event(OP_FALL, 16'd0);
    send_event(OP_FALL, 16'd13500);
    send_event(OP_RISE, 16'd560);
    send_event(OP_TIMEOUT, 16'd0);
    send_event(OP_RELEASE, 16'd0);
    send_event(OP_RELEASE, 16'd0);
  endtask

  task automatic test_frame_length();
    send_frame(33);
    send_event(OP_RELEASE, 16'd0);
    send_frame(40);
    send_event(OP_FALL, 16'd1125);
    send_frame(16);
  endtask

  task automatic test_back_pressure();
    settle();
    hold_cnt = 200;
    send_frame(32);
    send_event(OP_RELEASE, 16'd0);
  endtask

  task automatic test_ignored_registers();
    settle();
    for (int i = 4; i < 8; i++) write_reg(REG_IDX_W'(i), 16'($urandom));
    send_frame(32);
    send_event(OP_RELEASE, 16'd0);
  endtask

  task automatic test_register_extremes();
    set_timing(16'd0, 16'd0, 16'd0, 16'd0);
    random_traffic(100);
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_traffic(100);
  endtask

  task automatic test_random_timing();
    set_timing(PREAMBLE_RESET, ZERO_RESET, ONE_RESET, STOP_RESET);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_traffic(200);
    send_idle_pct = 11;
    recv_stall_pct = 11;
    repeat (2) begin
      set_timing(16'($urandom_range(30000, 3000)), 16'($urandom_range(2000, 200)),
                 16'($urandom_range(6000, 2100)), 16'($urandom_range(2000, 100)));
      random_traffic(200);
    end
    set_timing(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_traffic(100);
    set_timing(PREAMBLE_RESET, ZERO_RESET, ONE_RESET, STOP_RESET);
    random_traffic(150);
  endtask

  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      result_ch.ready <= 1'b0;
      hold_cnt = hold_cnt - 1;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 50)
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_status.size() == 0) begin
        errors++;
        if (errors <= 50)
          $display("%0t: unexpected result, expected none actual state %h", $time,
                   result_ch.receiver_state);
      end else begin
        head = expected_status.pop_front();
        check_field("receiver_state", head.state, result_ch.receiver_state);
        check_field("bytes_received", head.nbytes, result_ch.bytes_received);
        check_field("bit_position", head.nbits, result_ch.bit_position);
        check_field("frame_data", head.data, result_ch.frame_data);
        check_field("frame_valid", head.fvalid, result_ch.frame_valid);
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_ir_pulse_distance_receiver NOT OK");
      $finish;
    end
  end

  initial begin
    item_ch.valid = 1'b0;
    item_ch.opcode = OP_FALL;
    item_ch.duration_us = '0;
    result_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_line_events();
    test_held_frame();
    test_frame_length();
    test_back_pressure();
    test_ignored_registers();
    test_register_extremes();
    test_random_timing();
    settle();
    repeat (10) @(posedge clk);
    $display("%0d line events, %0d results checked, %0d frames sent, %0d held ready",
             n_sent, n_checked, n_frames, n_held);
    $display("%0d register writes: zero, maximum, default and random windows", n_writes);
    if (errors == 0 && expected_status.size() == 0) begin
      $display("tb_ir_pulse_distance_receiver OK");
    end else begin
      $display("tb_ir_pulse_distance_receiver NOT OK");
    end
    $finish;
  end

endmodule
